[rtl/etms_pkg.sv]
// ----------------------------------------------------------------------------
// Exact template match search package
// Shared codes, register indexes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package etms_pkg;

  localparam logic [1:0] CMD_TEMPLATE = 2'd0;
  localparam logic [1:0] CMD_IMAGE    = 2'd1;
  localparam logic [1:0] CMD_START    = 2'd2;

  localparam logic [1:0] ST_MATCH    = 2'd0;
  localparam logic [1:0] ST_DONE     = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;
  localparam logic [1:0] ST_SIZE_ERR = 2'd3;

  localparam logic [2:0] CFG_IMAGE_WIDTH     = 3'd0;
  localparam logic [2:0] CFG_IMAGE_HEIGHT    = 3'd1;
  localparam logic [2:0] CFG_TEMPLATE_WIDTH  = 3'd2;
  localparam logic [2:0] CFG_TEMPLATE_HEIGHT = 3'd3;
  localparam logic [2:0] CFG_WINDOW_LEFT     = 3'd4;
  localparam logic [2:0] CFG_WINDOW_TOP      = 3'd5;
  localparam logic [2:0] CFG_WINDOW_RIGHT    = 3'd6;
  localparam logic [2:0] CFG_WINDOW_BOTTOM   = 3'd7;

  // Origin coordinates reach one past the largest window edge.
  localparam int COORD_W = 8;

  typedef struct packed {
    logic write_tmpl;
    logic write_img;
    logic init;
    logic setup;
    logic next_col;
    logic next_row;
    logic clear_off;
    logic step_off;
    logic emit_match;
    logic emit_close;
    logic set_err;
    logic set_ovf;
  } etms_cmd_t;

  typedef struct packed {
    logic size_err;
    logic col_done;
    logic row_done;
    logic pix_eq;
    logic off_last;
    logic count_full;
    logic out_free;
  } etms_stat_t;

endpackage

[rtl/etms_ctrl.sv]
// ----------------------------------------------------------------------------
// Exact template match search controller
// Sequences loads, the origin walk, the pixel compare loop and result output.
// ----------------------------------------------------------------------------
module etms_ctrl
  import etms_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] cmd,
  input  etms_stat_t stat,
  output etms_cmd_t  ctl
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SETUP  = 3'd1;
  localparam logic [2:0] S_ORIGIN = 3'd2;
  localparam logic [2:0] S_READ   = 3'd3;
  localparam logic [2:0] S_CMP    = 3'd4;
  localparam logic [2:0] S_EMIT   = 3'd5;
  localparam logic [2:0] S_CLOSE  = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    ctl        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          case (cmd)
            CMD_TEMPLATE: ctl.write_tmpl = 1'b1;
            CMD_IMAGE:    ctl.write_img  = 1'b1;
            CMD_START: begin
              ctl.init   = 1'b1;
              state_next = S_SETUP;
            end
            default: ;
          endcase
        end
      end
      S_SETUP: begin
        if (stat.size_err) begin
          ctl.set_err = 1'b1;
          state_next  = S_CLOSE;
        end else begin
          ctl.setup  = 1'b1;
          state_next = S_ORIGIN;
        end
      end
      S_ORIGIN: begin
        if (stat.col_done) begin
          state_next = S_CLOSE;
        end else if (stat.row_done) begin
          ctl.next_col = 1'b1;
        end else begin
          ctl.clear_off = 1'b1;
          state_next    = S_READ;
        end
      end
      S_READ: begin
        state_next = S_CMP;
      end
      S_CMP: begin
        if (!stat.pix_eq) begin
          ctl.next_row = 1'b1;
          state_next   = S_ORIGIN;
        end else if (stat.off_last) begin
          state_next = S_EMIT;
        end else begin
          ctl.step_off = 1'b1;
          state_next   = S_READ;
        end
      end
      S_EMIT: begin
        if (stat.count_full) begin
          ctl.set_ovf = 1'b1;
          state_next  = S_CLOSE;
        end else if (stat.out_free) begin
          ctl.emit_match = 1'b1;
          state_next     = S_ORIGIN;
        end
      end
      S_CLOSE: begin
        if (stat.out_free) begin
          ctl.emit_close = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

[rtl/etms_datapath.sv]
// ----------------------------------------------------------------------------
// Exact template match search datapath
// Configuration registers, pixel stores, search counters and result register.
// ----------------------------------------------------------------------------
module etms_datapath
  import etms_pkg::*;
#(
  parameter int IMAGE_SIDE_MAX    = 128,
  parameter int TEMPLATE_SIDE_MAX = 16,
  parameter int MAX_MATCHES       = 63
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic [6:0]  col,
  input  logic [6:0]  row,
  input  logic [31:0] pixel_value,
  input  etms_cmd_t   ctl,
  output etms_stat_t  stat,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [6:0]  match_col,
  output logic [6:0]  match_row,
  output logic [1:0]  status,
  output logic        last
);

  localparam int IMG_DEPTH = IMAGE_SIDE_MAX * IMAGE_SIDE_MAX;
  localparam int TPL_DEPTH = TEMPLATE_SIDE_MAX * TEMPLATE_SIDE_MAX;
  localparam int IA_W      = $clog2(IMG_DEPTH);
  localparam int TA_W      = (TPL_DEPTH > 1) ? $clog2(TPL_DEPTH) : 1;

  logic [7:0] image_width;
  logic [7:0] image_height;
  logic [4:0] template_width;
  logic [4:0] template_height;
  logic [6:0] window_left;
  logic [6:0] window_top;
  logic [6:0] window_right;
  logic [6:0] window_bottom;

  logic [31:0] image_store [IMG_DEPTH];
  logic [31:0] template_store [TPL_DEPTH];
  logic [31:0] img_rdata;
  logic [31:0] tpl_rdata;

  logic [7:0]         iw;
  logic [7:0]         ih;
  logic [4:0]         tw;
  logic [4:0]         th;
  logic [COORD_W-1:0] right;
  logic [COORD_W-1:0] bottom;
  logic [COORD_W-1:0] x;
  logic [COORD_W-1:0] y;
  logic [4:0]         ox;
  logic [4:0]         oy;
  logic [5:0]         match_count;
  logic               err_flag;
  logic               ovf_flag;

  logic [7:0]         iw_next;
  logic [7:0]         ih_next;
  logic [4:0]         tw_next;
  logic [4:0]         th_next;
  logic [7:0]         span_w;
  logic [7:0]         span_h;
  logic [COORD_W-1:0] right_next;
  logic [COORD_W-1:0] bottom_next;
  logic [8:0]         img_x;
  logic [8:0]         img_y;
  logic [IA_W-1:0]    img_raddr;
  logic [TA_W-1:0]    tpl_raddr;
  logic [IA_W-1:0]    img_waddr;
  logic [TA_W-1:0]    tpl_waddr;
  logic               img_in_range;
  logic               tpl_in_range;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width     <= 8'd128;
      image_height    <= 8'd128;
      template_width  <= 5'd16;
      template_height <= 5'd16;
      window_left     <= 7'd0;
      window_top      <= 7'd0;
      window_right    <= 7'd127;
      window_bottom   <= 7'd127;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:     image_width     <= cfg_data;
        CFG_IMAGE_HEIGHT:    image_height    <= cfg_data;
        CFG_TEMPLATE_WIDTH:  template_width  <= cfg_data[4:0];
        CFG_TEMPLATE_HEIGHT: template_height <= cfg_data[4:0];
        CFG_WINDOW_LEFT:     window_left     <= cfg_data[6:0];
        CFG_WINDOW_TOP:      window_top      <= cfg_data[6:0];
        CFG_WINDOW_RIGHT:    window_right    <= cfg_data[6:0];
        CFG_WINDOW_BOTTOM:   window_bottom   <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // Size registers of zero count as one, and larger ones saturate at the store side.
  always_comb begin
    iw_next = image_width;
    if (image_width == 8'd0) begin
      iw_next = 8'd1;
    end else if (32'(image_width) > IMAGE_SIDE_MAX) begin
      iw_next = 8'(IMAGE_SIDE_MAX);
    end
    ih_next = image_height;
    if (image_height == 8'd0) begin
      ih_next = 8'd1;
    end else if (32'(image_height) > IMAGE_SIDE_MAX) begin
      ih_next = 8'(IMAGE_SIDE_MAX);
    end
    tw_next = template_width;
    if (template_width == 5'd0) begin
      tw_next = 5'd1;
    end else if (32'(template_width) > TEMPLATE_SIDE_MAX) begin
      tw_next = 5'(TEMPLATE_SIDE_MAX);
    end
    th_next = template_height;
    if (template_height == 5'd0) begin
      th_next = 5'd1;
    end else if (32'(template_height) > TEMPLATE_SIDE_MAX) begin
      th_next = 5'(TEMPLATE_SIDE_MAX);
    end
  end

  assign span_w = iw - 8'(tw);
  assign span_h = ih - 8'(th);
  assign right_next  = ({1'b0, window_right} > span_w) ? span_w : {1'b0, window_right};
  assign bottom_next = ({1'b0, window_bottom} > span_h) ? span_h : {1'b0, window_bottom};

  always_ff @(posedge clk) begin
    if (ctl.init) begin
      iw <= iw_next;
      ih <= ih_next;
      tw <= tw_next;
      th <= th_next;
    end
    if (ctl.setup) begin
      right  <= right_next;
      bottom <= bottom_next;
    end
    if (ctl.setup || ctl.next_col) begin
      y <= {1'b0, window_top};
    end else if (ctl.next_row || ctl.emit_match) begin
      y <= y + 1'b1;
    end
    if (ctl.setup) begin
      x <= {1'b0, window_left};
    end else if (ctl.next_col) begin
      x <= x + 1'b1;
    end
    if (ctl.clear_off) begin
      ox <= 5'd0;
      oy <= 5'd0;
    end else if (ctl.step_off) begin
      if (oy == th - 5'd1) begin
        oy <= 5'd0;
        ox <= ox + 5'd1;
      end else begin
        oy <= oy + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      match_count <= 6'd0;
      err_flag    <= 1'b0;
      ovf_flag    <= 1'b0;
    end else begin
      if (ctl.init) begin
        match_count <= 6'd0;
        err_flag    <= 1'b0;
        ovf_flag    <= 1'b0;
      end
      if (ctl.emit_match) begin
        match_count <= match_count + 6'd1;
      end
      if (ctl.set_err) begin
        err_flag <= 1'b1;
      end
      if (ctl.set_ovf) begin
        ovf_flag <= 1'b1;
      end
    end
  end

  assign img_x     = {1'b0, x} + 9'(ox);
  assign img_y     = {1'b0, y} + 9'(oy);
  assign img_raddr = IA_W'(32'(img_y) * IMAGE_SIDE_MAX + 32'(img_x));
  assign tpl_raddr = TA_W'(32'(oy) * TEMPLATE_SIDE_MAX + 32'(ox));
  assign img_waddr = IA_W'(32'(row) * IMAGE_SIDE_MAX + 32'(col));
  assign tpl_waddr = TA_W'(32'(row) * TEMPLATE_SIDE_MAX + 32'(col));
  assign img_in_range = (32'(col) < IMAGE_SIDE_MAX) && (32'(row) < IMAGE_SIDE_MAX);
  assign tpl_in_range = (32'(col) < TEMPLATE_SIDE_MAX) && (32'(row) < TEMPLATE_SIDE_MAX);

  always_ff @(posedge clk) begin
    if (ctl.write_img && img_in_range) begin
      image_store[img_waddr] <= pixel_value;
    end
    img_rdata <= image_store[img_raddr];
  end

  always_ff @(posedge clk) begin
    if (ctl.write_tmpl && tpl_in_range) begin
      template_store[tpl_waddr] <= pixel_value;
    end
    tpl_rdata <= template_store[tpl_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.emit_match || ctl.emit_close) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit_match) begin
      match_col <= x[6:0];
      match_row <= y[6:0];
      status    <= ST_MATCH;
      last      <= 1'b0;
    end else if (ctl.emit_close) begin
      match_col <= 7'd0;
      match_row <= 7'd0;
      status    <= err_flag ? ST_SIZE_ERR : (ovf_flag ? ST_OVERFLOW : ST_DONE);
      last      <= 1'b1;
    end
  end

  assign stat.size_err   = (tw > iw[4:0] && iw < 8'd32) || (th > ih[4:0] && ih < 8'd32);
  assign stat.col_done   = x > right;
  assign stat.row_done   = y > bottom;
  assign stat.pix_eq     = img_rdata == tpl_rdata;
  assign stat.off_last   = (ox == tw - 5'd1) && (oy == th - 5'd1);
  assign stat.count_full = 32'(match_count) >= MAX_MATCHES;
  assign stat.out_free   = !out_valid || out_ready;

endmodule

[rtl/exact_template_match_search_top.sv]
// Sequence: a pixel load is taken while idle. A search passes a setup state, an origin check per
// origin, a read and a compare state per compared pixel, a column step per origin column and a
// final check to end the walk, and an emit state per result that waits for out_ready.
// Throughput: one load per cycle; a start holds off input until its closing result is issued.
// Reset: synchronous; clears control, flags, match count and configuration registers.
// The pixel stores are undefined until written and get no clearing pass.
// ----------------------------------------------------------------------------
// Exact template match search top level
// Loads template and image pixels and reports each exact match in a window, up to MAX_MATCHES.
// ----------------------------------------------------------------------------
module exact_template_match_search_top
  import etms_pkg::*;
#(
  parameter int IMAGE_SIDE_MAX    = 128,
  parameter int TEMPLATE_SIDE_MAX = 16,
  parameter int MAX_MATCHES       = 63
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  cmd,
  input  logic [6:0]  col,
  input  logic [6:0]  row,
  input  logic [31:0] pixel_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [6:0]  match_col,
  output logic [6:0]  match_row,
  output logic [1:0]  status,
  output logic        last
);

  etms_cmd_t  ctl;
  etms_stat_t stat;

  assign cfg_ready = 1'b1;

  etms_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .stat     (stat),
    .ctl      (ctl)
  );

  etms_datapath #(
    .IMAGE_SIDE_MAX    (IMAGE_SIDE_MAX),
    .TEMPLATE_SIDE_MAX (TEMPLATE_SIDE_MAX),
    .MAX_MATCHES       (MAX_MATCHES)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .col         (col),
    .row         (row),
    .pixel_value (pixel_value),
    .ctl         (ctl),
    .stat        (stat),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .match_col   (match_col),
    .match_row   (match_row),
    .status      (status),
    .last        (last)
  );

endmodule

[rtl/etms_checker.sv]
// ----------------------------------------------------------------------------
// Exact template match search checker
// Port-level properties of the search block, bound to the top level.
// ----------------------------------------------------------------------------
module etms_checker
  import etms_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic [1:0] cmd,
  input logic       out_valid,
  input logic       out_ready,
  input logic [6:0] match_col,
  input logic [6:0] match_row,
  input logic [1:0] status,
  input logic       last
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("Result item dropped before it was taken.");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(match_col) && $stable(match_row)
      && $stable(status) && $stable(last))
    else $error("Stalled result item changed.");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && cmd == CMD_START |=> !in_ready)
    else $error("Input accepted right after a search start.");

  a_last_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((status == ST_MATCH) == !last))
    else $error("Closing flag does not agree with the result status.");

  a_close_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && last |-> match_col == 7'd0 && match_row == 7'd0)
    else $error("Closing result carries a nonzero origin.");

endmodule

bind exact_template_match_search_top etms_checker u_etms_checker (.*);
